### rtl/nmd_pkg.sv
`default_nettype none

package nmd_pkg;

   // default counter limits
   localparam int FIELD_INDEX_MAX_DEF = 31;
   localparam int POSITION_MAX_DEF    = 127;

   // result field widths
   localparam int FIELD_NUMBER_W  = 5;
   localparam int CHAR_POSITION_W = 7;
   localparam int RSP_DATA_W      = 40;

   // framing characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_BODY = 2'd1,
      PHASE_HEX1 = 2'd2,
      PHASE_HEX2 = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_BAD_HEX  = 2'd3
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_END     = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                     kind;
      logic [7:0]                   char_out;
      logic [FIELD_NUMBER_W-1:0]    field_number;
      logic [CHAR_POSITION_W-1:0]   char_position;
      status_type                   status;
      logic [7:0]                   computed_sum;
      logic [7:0]                   received_sum;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_type;

   // ascii hex digit decode, either case
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid  = 1'b1;
      h.nibble = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         h.nibble = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         h.nibble = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

### rtl/nmea_sentence_deframer_top.sv
// each byte is held in the input register and decoded, and its result, if any, is registered in the result register
// throughput: one byte per cycle; input register, decode logic and result register
// run back to back, stalled only by the result register when it is full and not taken
// reset: synchronous, active high; returns to idle waiting for a dollar and empties
// both registers
`default_nettype none

module nmea_sentence_deframer_top #(
   parameter int FIELD_INDEX_MAX = nmd_pkg::FIELD_INDEX_MAX_DEF,
   parameter int POSITION_MAX    = nmd_pkg::POSITION_MAX_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   // [7:0] char_out, [12:8] field_number, [19:13] char_position, [21:20] status,
   // [29:22] computed_sum, [37:30] received_sum, [39:38] zero
   output logic [nmd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic            rsp_tuser    // [0] kind
);

   logic                byte_valid;
   logic [7:0]          byte_data;
   logic                out_ready;
   logic                advance;
   logic                res_valid;
   nmd_pkg::result_type res;

   // byte moves into the parser when the result side has room
   assign advance = byte_valid && out_ready;

   nmd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   nmd_parser #(
      .FIELD_INDEX_MAX (FIELD_INDEX_MAX),
      .POSITION_MAX    (POSITION_MAX)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .in_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   nmd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### rtl/nmd_in_reg.sv
`default_nettype none

module nmd_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       take;

   // slot frees when its byte moves on
   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // byte holding register
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_tdata;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

`default_nettype wire

### rtl/nmd_parser.sv
`default_nettype none

module nmd_parser #(
   parameter int FIELD_INDEX_MAX = nmd_pkg::FIELD_INDEX_MAX_DEF,
   parameter int POSITION_MAX    = nmd_pkg::POSITION_MAX_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  wire logic [7:0]    in_byte,
   output logic               res_valid,
   output nmd_pkg::result_type res
);

   localparam int FW = $clog2(FIELD_INDEX_MAX + 1);
   localparam int PW = $clog2(POSITION_MAX + 1);
   localparam int FNW = nmd_pkg::FIELD_NUMBER_W;
   localparam int CPW = nmd_pkg::CHAR_POSITION_W;

   nmd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         xor_ff, xor_in;
   logic [3:0]         nibble_ff, nibble_in;
   logic [FW-1:0]      field_ff, field_in;
   logic [PW-1:0]      pos_ff, pos_in;

   logic               is_dollar, is_star, is_comma, line_end;
   nmd_pkg::hex_type   hex;
   logic [7:0]         rsum;

   assign is_dollar = (in_byte == nmd_pkg::CHAR_DOLLAR);
   assign is_star   = (in_byte == nmd_pkg::CHAR_STAR);
   assign is_comma  = (in_byte == nmd_pkg::CHAR_COMMA);
   assign line_end  = (in_byte == nmd_pkg::CHAR_CR) || (in_byte == nmd_pkg::CHAR_LF);
   assign hex       = nmd_pkg::hex_decode(in_byte);
   assign rsum      = {nibble_ff, hex.nibble};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (is_dollar) begin
            phase_in = nmd_pkg::PHASE_BODY;
         end else begin
            case (phase_ff)
               nmd_pkg::PHASE_IDLE: phase_in = nmd_pkg::PHASE_IDLE;
               nmd_pkg::PHASE_BODY: begin
                  if (is_star) begin
                     phase_in = nmd_pkg::PHASE_HEX1;
                  end else if (line_end) begin
                     phase_in = nmd_pkg::PHASE_IDLE;
                  end
               end
               nmd_pkg::PHASE_HEX1: begin
                  if (line_end || !hex.valid) begin
                     phase_in = nmd_pkg::PHASE_IDLE;
                  end else begin
                     phase_in = nmd_pkg::PHASE_HEX2;
                  end
               end
               nmd_pkg::PHASE_HEX2: phase_in = nmd_pkg::PHASE_IDLE;
               default:             phase_in = nmd_pkg::PHASE_IDLE;
            endcase
         end
      end
   end

   // datapath updates and result
   always_comb begin
      xor_in    = xor_ff;
      nibble_in = nibble_ff;
      field_in  = field_ff;
      pos_in    = pos_ff;
      res_valid = 1'b0;

      res.kind          = nmd_pkg::KIND_END;
      res.char_out      = 8'd0;
      res.field_number  = FNW'(field_ff);
      res.char_position = CPW'(pos_ff);
      res.status        = nmd_pkg::STATUS_OK;
      res.computed_sum  = xor_ff;
      res.received_sum  = 8'd0;

      if (step) begin
         if (is_dollar) begin
            xor_in    = 8'd0;
            nibble_in = 4'd0;
            field_in  = '0;
            pos_in    = '0;
         end else begin
            case (phase_ff)
               nmd_pkg::PHASE_IDLE: ;
               nmd_pkg::PHASE_BODY: begin
                  if (line_end) begin
                     res_valid  = 1'b1;
                     res.status = nmd_pkg::STATUS_SHORT;
                  end else if (!is_star) begin
                     xor_in = xor_ff ^ in_byte;
                     if (is_comma) begin
                        if (field_ff < FW'(FIELD_INDEX_MAX)) begin
                           field_in = field_ff + 1'b1;
                        end
                        pos_in = '0;
                     end else begin
                        res_valid        = 1'b1;
                        res.kind         = nmd_pkg::KIND_PAYLOAD;
                        res.char_out     = in_byte;
                        res.computed_sum = 8'd0;
                        if (pos_ff < PW'(POSITION_MAX)) begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end
                  end
               end
               nmd_pkg::PHASE_HEX1: begin
                  if (line_end) begin
                     res_valid  = 1'b1;
                     res.status = nmd_pkg::STATUS_SHORT;
                  end else if (!hex.valid) begin
                     res_valid  = 1'b1;
                     res.status = nmd_pkg::STATUS_BAD_HEX;
                  end else begin
                     nibble_in = hex.nibble;
                  end
               end
               nmd_pkg::PHASE_HEX2: begin
                  res_valid = 1'b1;
                  if (line_end) begin
                     res.status = nmd_pkg::STATUS_SHORT;
                  end else if (!hex.valid) begin
                     res.status = nmd_pkg::STATUS_BAD_HEX;
                  end else begin
                     res.received_sum = rsum;
                     res.status = (rsum == xor_ff) ? nmd_pkg::STATUS_OK
                                                   : nmd_pkg::STATUS_MISMATCH;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= nmd_pkg::PHASE_IDLE;
         xor_ff    <= 8'd0;
         nibble_ff <= 4'd0;
         field_ff  <= '0;
         pos_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         xor_ff    <= xor_in;
         nibble_ff <= nibble_in;
         field_ff  <= field_in;
         pos_ff    <= pos_in;
      end
   end

   // a dollar always opens a clean sentence
   assert property (@(posedge clock) disable iff (reset)
      step && is_dollar |=> phase_ff == nmd_pkg::PHASE_BODY && xor_ff == 8'd0
         && field_ff == '0 && pos_ff == '0)
      else $error("sentence start did not clear state");

   // second hex digit always closes the sentence with a result
   assert property (@(posedge clock) disable iff (reset)
      step && !is_dollar && phase_ff == nmd_pkg::PHASE_HEX2
         |-> res_valid ##1 phase_ff == nmd_pkg::PHASE_IDLE)
      else $error("checksum tail did not end the sentence");

   // counters never pass their limits
   assert property (@(posedge clock) disable iff (reset)
      field_ff <= FW'(FIELD_INDEX_MAX) && pos_ff <= PW'(POSITION_MAX))
      else $error("counter beyond its limit");

   // an idle block only wakes on a dollar
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == nmd_pkg::PHASE_IDLE && !(step && is_dollar)
         |=> phase_ff == nmd_pkg::PHASE_IDLE)
      else $error("left idle without a dollar");

endmodule

`default_nettype wire

### rtl/nmd_out_reg.sv
`default_nettype none

module nmd_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               advance,
   input  wire logic               res_valid,
   input  wire nmd_pkg::result_type res,
   output logic                    out_ready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [nmd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                    rsp_tuser
);

   logic                valid_ff, valid_in;
   nmd_pkg::result_type res_ff;
   logic                load;

   // free when empty or being drained this cycle
   assign out_ready = !valid_ff || rsp_tready;
   assign load      = advance && res_valid;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      if (advance) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {2'b00, res_ff.received_sum, res_ff.computed_sum, res_ff.status,
                        res_ff.char_position, res_ff.field_number, res_ff.char_out};

endmodule

`default_nettype wire

### bench/tb_nmea_sentence_deframer_top.sv
`default_nettype none

module tb_nmea_sentence_deframer_top;

   localparam int FIELD_LIMIT  = nmd_pkg::FIELD_INDEX_MAX_DEF;
   localparam int POS_LIMIT    = nmd_pkg::POSITION_MAX_DEF;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FNW          = nmd_pkg::FIELD_NUMBER_W;
   localparam int CPW          = nmd_pkg::CHAR_POSITION_W;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = 8'h00;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [nmd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   // bytes waiting to be offered, results the deframer still owes
   logic [7:0]          pending_bytes [$];
   nmd_pkg::result_type deframed_results [$];

   // sentence state tracked alongside the block
   nmd_pkg::phase_type frame_phase = nmd_pkg::PHASE_IDLE;
   logic [7:0] frame_xor = 8'h00;
   logic [3:0] frame_high_nibble = 4'h0;
   int         frame_field = 0;
   int         frame_pos = 0;

   // idling controls; the percentages and the hold trigger change only at falling edges
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_left = 0;

   int counted_items = 0;
   int accepted_bytes = 0;
   int payload_seen = 0;
   int end_by_status [4] = '{0, 0, 0, 0};
   int mismatch_count = 0;
   int cycle_count = 0;

   nmea_sentence_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ascii hex digit value, -1 when not a digit
   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   // end-of-sentence result from the current counters
   function automatic nmd_pkg::result_type sentence_end(input nmd_pkg::status_type st,
                                                        input logic [7:0] rsum);
      nmd_pkg::result_type r;
      r               = '0;
      r.kind          = nmd_pkg::KIND_END;
      r.field_number  = frame_field[FNW-1:0];
      r.char_position = frame_pos[CPW-1:0];
      r.status        = st;
      r.computed_sum  = frame_xor;
      r.received_sum  = rsum;
      return r;
   endfunction

   // advance the sentence state by one accepted byte, queue any result
   task automatic deframe_byte(input logic [7:0] c);
      nmd_pkg::result_type r;
      logic       line_end;
      int         hv;
      logic [7:0] rsum;
      line_end = (c == nmd_pkg::CHAR_CR) || (c == nmd_pkg::CHAR_LF);
      if (c == nmd_pkg::CHAR_DOLLAR) begin
         frame_phase       = nmd_pkg::PHASE_BODY;
         frame_xor         = 8'h00;
         frame_high_nibble = 4'h0;
         frame_field       = 0;
         frame_pos         = 0;
      end else begin
         case (frame_phase)
            nmd_pkg::PHASE_IDLE: begin
            end
            nmd_pkg::PHASE_BODY: begin
               if (c == nmd_pkg::CHAR_STAR) begin
                  frame_phase = nmd_pkg::PHASE_HEX1;
               end else if (line_end) begin
                  frame_phase = nmd_pkg::PHASE_IDLE;
                  deframed_results.push_back(sentence_end(nmd_pkg::STATUS_SHORT, 8'h00));
               end else begin
                  frame_xor = frame_xor ^ c;
                  if (c == nmd_pkg::CHAR_COMMA) begin
                     if (frame_field < FIELD_LIMIT) frame_field++;
                     frame_pos = 0;
                  end else begin
                     r               = '0;
                     r.kind          = nmd_pkg::KIND_PAYLOAD;
                     r.char_out      = c;
                     r.field_number  = frame_field[FNW-1:0];
                     r.char_position = frame_pos[CPW-1:0];
                     r.status        = nmd_pkg::STATUS_OK;
                     deframed_results.push_back(r);
                     if (frame_pos < POS_LIMIT) frame_pos++;
                  end
               end
            end
            nmd_pkg::PHASE_HEX1: begin
               hv = hex_digit_value(c);
               if (line_end) begin
                  frame_phase = nmd_pkg::PHASE_IDLE;
                  deframed_results.push_back(sentence_end(nmd_pkg::STATUS_SHORT, 8'h00));
               end else if (hv < 0) begin
                  frame_phase = nmd_pkg::PHASE_IDLE;
                  deframed_results.push_back(sentence_end(nmd_pkg::STATUS_BAD_HEX, 8'h00));
               end else begin
                  frame_high_nibble = hv[3:0];
                  frame_phase       = nmd_pkg::PHASE_HEX2;
               end
            end
            default: begin
               hv          = hex_digit_value(c);
               frame_phase = nmd_pkg::PHASE_IDLE;
               if (line_end) begin
                  deframed_results.push_back(sentence_end(nmd_pkg::STATUS_SHORT, 8'h00));
               end else if (hv < 0) begin
                  deframed_results.push_back(sentence_end(nmd_pkg::STATUS_BAD_HEX, 8'h00));
               end else begin
                  rsum = {frame_high_nibble, hv[3:0]};
                  if (rsum == frame_xor) begin
                     deframed_results.push_back(sentence_end(nmd_pkg::STATUS_OK, rsum));
                  end else begin
                     deframed_results.push_back(sentence_end(nmd_pkg::STATUS_MISMATCH, rsum));
                  end
               end
            end
         endcase
      end
   endtask

   // driver: offer queued bytes, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            accepted_bytes++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic compare_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // monitor: check each result transfer against the oldest expectation
   always @(posedge clock) begin : result_monitor
      nmd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser) end_by_status[rsp_tdata[21:20]]++;
         else payload_seen++;
         if (deframed_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatch_count++;
         end else begin
            want = deframed_results.pop_front();
            compare_field("kind", int'(want.kind), int'(rsp_tuser));
            compare_field("char_out", int'(want.char_out), int'(rsp_tdata[7:0]));
            compare_field("field_number", int'(want.field_number), int'(rsp_tdata[12:8]));
            compare_field("char_position", int'(want.char_position),
                          int'(rsp_tdata[19:13]));
            compare_field("status", int'(want.status), int'(rsp_tdata[21:20]));
            compare_field("computed_sum", int'(want.computed_sum), int'(rsp_tdata[29:22]));
            compare_field("received_sum", int'(want.received_sum), int'(rsp_tdata[37:30]));
            compare_field("pad", 0, int'(rsp_tdata[39:38]));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_nmea_sentence_deframer_top: done, errors");
      $finish;
   end

   // stimulus helpers
   task automatic push_byte(input logic [7:0] b, input bit counted);
      pending_bytes.push_back(b);
      if (counted) counted_items++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b1);
   endtask

   function automatic logic [7:0] body_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == nmd_pkg::CHAR_DOLLAR || b == nmd_pkg::CHAR_STAR
             || b == nmd_pkg::CHAR_CR || b == nmd_pkg::CHAR_LF)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] bad_hex_char();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (hex_digit_value(b) >= 0 || b == nmd_pkg::CHAR_DOLLAR
             || b == nmd_pkg::CHAR_CR || b == nmd_pkg::CHAR_LF)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] line_end_char();
      return $urandom_range(0, 1) ? nmd_pkg::CHAR_CR : nmd_pkg::CHAR_LF;
   endfunction

   // one random sentence, mostly well formed, some broken, some noise
   task automatic add_sentence();
      int         pick;
      int         fields;
      int         len;
      bit         lower;
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] sent_sum;
      pick  = $urandom_range(0, 99);
      lower = 1'($urandom_range(0, 1));
      sum   = 8'h00;
      if (pick < 8) begin
         // line noise, only matters when it hits a dollar or follows a sentence left open
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         push_byte(nmd_pkg::CHAR_DOLLAR, 1'b1);
         if (pick < 11) begin
            // saturate either the field index or the position
            if ($urandom_range(0, 1)) begin
               repeat ($urandom_range(33, 40)) begin
                  push_byte(nmd_pkg::CHAR_COMMA, 1'b1);
                  sum = sum ^ nmd_pkg::CHAR_COMMA;
               end
               b = body_char();
               push_byte(b, 1'b1);
               sum = sum ^ b;
            end else begin
               repeat ($urandom_range(128, 140)) begin
                  b = body_char();
                  push_byte(b, 1'b1);
                  sum = sum ^ b;
               end
            end
         end else begin
            fields = $urandom_range(1, 6);
            for (int f = 0; f < fields; f++) begin
               if (f > 0) begin
                  push_byte(nmd_pkg::CHAR_COMMA, 1'b1);
                  sum = sum ^ nmd_pkg::CHAR_COMMA;
               end
               len = $urandom_range(0, 6);
               repeat (len) begin
                  b = body_char();
                  push_byte(b, 1'b1);
                  sum = sum ^ b;
               end
            end
         end
         // tail of the sentence
         if (pick < 75) begin
            sent_sum = sum;
            if ($urandom_range(0, 9) == 0) sent_sum = sum ^ 8'($urandom_range(1, 255));
            push_byte(nmd_pkg::CHAR_STAR, 1'b1);
            push_byte(hex_char(sent_sum[7:4], lower), 1'b1);
            push_byte(hex_char(sent_sum[3:0], lower), 1'b1);
            push_byte(nmd_pkg::CHAR_CR, 1'b1);
            push_byte(nmd_pkg::CHAR_LF, 1'b1);
         end else if (pick < 80) begin
            push_byte(line_end_char(), 1'b1);
         end else if (pick < 84) begin
            push_byte(nmd_pkg::CHAR_STAR, 1'b1);
            push_byte(line_end_char(), 1'b1);
         end else if (pick < 88) begin
            push_byte(nmd_pkg::CHAR_STAR, 1'b1);
            push_byte(hex_char(sum[7:4], lower), 1'b1);
            push_byte(line_end_char(), 1'b1);
         end else if (pick < 92) begin
            push_byte(nmd_pkg::CHAR_STAR, 1'b1);
            push_byte(bad_hex_char(), 1'b1);
         end else if (pick < 96) begin
            push_byte(nmd_pkg::CHAR_STAR, 1'b1);
            push_byte(hex_char(sum[7:4], lower), 1'b1);
            push_byte(bad_hex_char(), 1'b1);
         end
         // otherwise left open, the next dollar restarts it
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || deframed_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random(input int n, input int idle_pct, input int stall_pct);
      @(negedge clock);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      counted_items      = 0;
      while (counted_items < n) add_sentence();
      wait_drained();
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: ignored bytes while idle
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_text("A");
      // byte extremes in the body, empty fields, good checksum in upper case
      push_text("$");
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_text(",,a*9E");
      // dollar mid-sentence, then a bad second hex digit
      push_text("$Q$R*1G");
      // line end in the first hex digit and in the body
      push_text("$*\n");
      push_text("$Z\r");
      // checksum mismatch in lower case
      push_text("$*ff");
      wait_drained();

      // random phases with different idling
      run_random(300, 0, 0);
      run_random(220, 73, 0);
      run_random(220, 0, 73);
      run_random(160, 12, 12);

      // long receiver hold-off while the sender keeps offering
      @(negedge clock);
      hold_trigger++;
      run_random(150, 0, 0);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (deframed_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, deframed_results.size());
         mismatch_count++;
      end

      $display("covered %0d accepted bytes, %0d payload characters, %0d sentence ends",
               accepted_bytes, payload_seen,
               end_by_status[0] + end_by_status[1] + end_by_status[2] + end_by_status[3]);
      $display("end status seen: ok %0d, mismatch %0d, cut short %0d, bad hex %0d",
               end_by_status[0], end_by_status[1], end_by_status[2], end_by_status[3]);
      if (mismatch_count == 0) begin
         $display("tb_nmea_sentence_deframer_top: done, clean");
      end else begin
         $display("tb_nmea_sentence_deframer_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### nmea_sentence_deframer_top.f
rtl/nmd_pkg.sv
rtl/nmd_in_reg.sv
rtl/nmd_parser.sv
rtl/nmd_out_reg.sv
rtl/nmea_sentence_deframer_top.sv
bench/tb_nmea_sentence_deframer_top.sv
